// ===== src/tesa_pkg.sv =====
// Shared types and constants for the two-ended table space allocator.
package tesa_pkg;

    localparam int CFG_W = 13;
    localparam int CFG_IDX_W = 2;
    localparam int PAGES_W = 13;
    localparam int PCT_W = 7;
    localparam int COUNT_W = 16;
    localparam int START_W = 24;
    localparam int LENGTH_W = 19;
    localparam int PROD_W = 19;
    localparam int RECIP_W = 24;
    localparam int RECIP_SHIFT = 30;

    localparam logic [PAGES_W-1:0] PAGES_MAX = 13'd4096;
    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
    localparam logic [PCT_W-1:0] PCT_MIN_SHARE = 7'd50;
    // Rounded-up reciprocal of one hundred, scaled by two to the RECIP_SHIFT.
    localparam logic [RECIP_W-1:0] PCT_RECIP = 24'd10737419;

    typedef enum logic [1:0] {
        CMD_ALLOC_LOW  = 2'd0,
        CMD_ALLOC_HIGH = 2'd1,
        CMD_RESET_LOW  = 2'd2,
        CMD_RESET_HIGH = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_CROSS = 2'd1,
        STATUS_SHARE = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REGION_PAGES = 2'd0,
        CFG_MAX_SHARE    = 2'd1,
        CFG_PAD          = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SIZE = 2'd1,
        ST_EXEC = 2'd2
    } state_t;

    typedef struct packed {
        cmd_t                command;
        logic [COUNT_W-1:0]  live_count;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [START_W-1:0]  table_start;
        logic [LENGTH_W-1:0] table_length;
    } rsp_t;

    typedef struct packed {
        logic load_req;
        logic size_en;
        logic exec_en;
    } dp_cmd_t;

    typedef struct packed {
        logic share_busy;
    } dp_status_t;

endpackage

// ===== src/two_ended_table_space_allocator.sv =====
// Top level of the two-ended table space allocator.
//
// One region of region_pages pages is shared by two bump allocators: the
// bottom end grows upward from word 0 and the top end grows downward from
// the region size. A request on the req channel carries a command and a live
// count; each request yields exactly one response on the rsp channel with a
// status, the table start word and the table length.
// A request is accepted when req_valid and req_ready are high. It is sized in
// the next cycle and then checked against both ends, and the result of the
// check is registered as the response. One request is in work at a time; it
// passes through acceptance, sizing and checking, in that order.
// The response register decouples the sides: the next request is accepted
// while a response still waits. When the receiver stalls, checking holds
// until the response register frees up.
// Writing region_pages or max_share_percent starts a division by one hundred
// for the share limit; req_ready is low meanwhile.
// Reset restores a full region of 4096 pages, a 100 percent share, no padding
// and both ends at their origins; no division runs after reset.
module two_ended_table_space_allocator #(
    parameter int LOG_WORDS_PER_PAGE = 12,
    parameter int MAX_LIVE_LOG = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tesa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tesa_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  tesa_pkg::req_t                 req_data,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output tesa_pkg::rsp_t                 rsp_data
);

    tesa_pkg::dp_cmd_t    cmd;
    tesa_pkg::dp_status_t status;

    tesa_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .status(status),
        .cmd(cmd)
    );

    tesa_datapath #(
        .LOG_WORDS_PER_PAGE(LOG_WORDS_PER_PAGE),
        .MAX_LIVE_LOG(MAX_LIVE_LOG)
    ) u_datapath (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .req_data(req_data),
        .cmd(cmd),
        .status(status),
        .rsp_data(rsp_data)
    );

endmodule

// ===== src/tesa_share_div.sv =====
// Three-step reciprocal division by one hundred that computes the share limit in words.
module tesa_share_div #(
    parameter int LOG_WORDS_PER_PAGE = 12
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    input  logic [tesa_pkg::PROD_W-1:0]                numerator,
    output logic                                       busy,
    output logic                                       done,
    output logic [tesa_pkg::PAGES_W+LOG_WORDS_PER_PAGE-1:0] quotient
);

    localparam int PROD_W = tesa_pkg::PROD_W;
    localparam int PCT_W = tesa_pkg::PCT_W;
    localparam int PAGES_W = tesa_pkg::PAGES_W;
    localparam int RECIP_W = tesa_pkg::RECIP_W;
    localparam int RECIP_SHIFT = tesa_pkg::RECIP_SHIFT;
    localparam int WORD_W = PAGES_W + LOG_WORDS_PER_PAGE;
    localparam int QPROD_W = PROD_W + RECIP_W;
    localparam int FIN_W = PCT_W + LOG_WORDS_PER_PAGE;
    localparam int FPROD_W = FIN_W + RECIP_W;
    localparam int STEPS = 3;
    localparam int CNT_W = $clog2(STEPS);

    logic               busy_reg;
    logic               busy_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [PROD_W-1:0]  num_reg;
    logic [PAGES_W-1:0] quo_reg;
    logic [PCT_W-1:0]   rem_reg;

    logic [QPROD_W-1:0] quo_prod;
    logic [PAGES_W-1:0] quo_step;
    logic [PROD_W-1:0]  quo_times;
    logic [PCT_W-1:0]   rem_step;
    logic [FIN_W-1:0]   frac_in;
    logic [FPROD_W-1:0] frac_prod;
    logic [LOG_WORDS_PER_PAGE-1:0] frac;
    logic               last;

    // The numerator is split into a multiple of one hundred and a remainder, and the
    // remainder is scaled by the page size before its own division.
    always_comb
    begin
        quo_prod = QPROD_W'(num_reg) * QPROD_W'(tesa_pkg::PCT_RECIP);
        quo_step = quo_prod[RECIP_SHIFT +: PAGES_W];
        quo_times = PROD_W'(quo_reg) * PROD_W'(tesa_pkg::PCT_FULL);
        rem_step = PCT_W'(num_reg - quo_times);
        frac_in = FIN_W'(rem_reg) << LOG_WORDS_PER_PAGE;
        frac_prod = FPROD_W'(frac_in) * FPROD_W'(tesa_pkg::PCT_RECIP);
        frac = frac_prod[RECIP_SHIFT +: LOG_WORDS_PER_PAGE];
        last = (cnt_reg == CNT_W'(STEPS - 1));
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        priority if (start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= numerator;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CNT_W'(0))
            begin
                quo_reg <= quo_step;
            end
            if (cnt_reg == CNT_W'(1))
            begin
                rem_reg <= rem_step;
            end
        end
    end

    assign busy = busy_reg;
    assign done = busy_reg && last;
    assign quotient = (WORD_W'(quo_reg) << LOG_WORDS_PER_PAGE) | WORD_W'(frac);

endmodule

// ===== src/tesa_datapath.sv =====
// Datapath: settings, end pointers, table sizing, bound checks and response register.
module tesa_datapath #(
    parameter int LOG_WORDS_PER_PAGE = 12,
    parameter int MAX_LIVE_LOG = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tesa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tesa_pkg::CFG_W-1:0]        cfg_data,
    input  tesa_pkg::req_t                    req_data,
    input  tesa_pkg::dp_cmd_t                 cmd,
    output tesa_pkg::dp_status_t              status,
    output tesa_pkg::rsp_t                    rsp_data
);

    localparam int PAGES_W = tesa_pkg::PAGES_W;
    localparam int PCT_W = tesa_pkg::PCT_W;
    localparam int PROD_W = tesa_pkg::PROD_W;
    localparam int COUNT_W = tesa_pkg::COUNT_W;
    localparam int WORD_W = PAGES_W + LOG_WORDS_PER_PAGE;
    localparam int L_W = (MAX_LIVE_LOG < COUNT_W) ? MAX_LIVE_LOG : COUNT_W;
    localparam int TOP_W = $clog2(L_W);
    localparam int T_W = L_W + 2;
    localparam int PADP_W = T_W + PCT_W;
    localparam int START_W = tesa_pkg::START_W;
    localparam int LENGTH_W = tesa_pkg::LENGTH_W;

    function automatic logic [PAGES_W-1:0] clamp_pages(input logic [PAGES_W-1:0] v);
        logic [PAGES_W-1:0] r;
        priority if (v == '0)
            r = PAGES_W'(1);
        else if (v > tesa_pkg::PAGES_MAX)
            r = tesa_pkg::PAGES_MAX;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [PCT_W-1:0] clamp_pct(input logic [PCT_W-1:0] v);
        logic [PCT_W-1:0] r;
        priority if (v < tesa_pkg::PCT_MIN_SHARE)
            r = tesa_pkg::PCT_MIN_SHARE;
        else if (v > tesa_pkg::PCT_FULL)
            r = tesa_pkg::PCT_FULL;
        else
            r = v;
        return r;
    endfunction

    logic [PAGES_W-1:0]  pages_reg, pages_next;
    logic [PCT_W-1:0]    pct_reg, pct_next;
    logic [PCT_W-1:0]    pad_reg, pad_next;
    logic [WORD_W-1:0]   low_end_reg, low_end_next;
    logic [WORD_W-1:0]   high_end_reg, high_end_next;
    logic [WORD_W-1:0]   share_reg, share_next;
    logic [WORD_W-1:0]   floor_reg, floor_next;
    tesa_pkg::req_t      req_reg;
    logic [T_W-1:0]      size_reg;
    tesa_pkg::rsp_t      rsp_reg;

    logic                region_write;
    logic                share_start;
    logic [PROD_W-1:0]   numerator;
    logic [WORD_W-1:0]   words;
    logic [WORD_W-1:0]   words_next;
    logic                div_busy;
    logic                div_done;
    logic [WORD_W-1:0]   div_quot;

    logic [L_W-1:0]      live;
    logic [TOP_W-1:0]    top;
    logic [T_W-1:0]      base;
    logic [T_W-1:0]      size_next;
    logic [L_W+PCT_W-1:0] pad_prod;
    logic [PADP_W-1:0]   pad_bound;

    logic [WORD_W-1:0]   size_ext;
    logic [WORD_W:0]     low_sum;
    logic [WORD_W-1:0]   high_diff;
    logic [WORD_W-1:0]   grant_low;
    logic [WORD_W-1:0]   grant_high;
    tesa_pkg::rsp_t      rsp_next;

    // Settings and share limit.
    always_comb
    begin
        region_write = cfg_we && (cfg_index == tesa_pkg::CFG_REGION_PAGES);
        share_start = region_write || (cfg_we && (cfg_index == tesa_pkg::CFG_MAX_SHARE));
        pages_next = region_write ? clamp_pages(cfg_data[PAGES_W-1:0]) : pages_reg;
        pct_next = (cfg_we && (cfg_index == tesa_pkg::CFG_MAX_SHARE))
                   ? clamp_pct(cfg_data[PCT_W-1:0]) : pct_reg;
        pad_next = (cfg_we && (cfg_index == tesa_pkg::CFG_PAD)) ? cfg_data[PCT_W-1:0] : pad_reg;
        numerator = PROD_W'(pages_next) * PROD_W'(pct_next);
        words = WORD_W'(pages_reg) << LOG_WORDS_PER_PAGE;
        words_next = WORD_W'(pages_next) << LOG_WORDS_PER_PAGE;
        share_next = div_done ? div_quot : share_reg;
        floor_next = div_done ? (words - div_quot) : floor_reg;
    end

    tesa_share_div #(
        .LOG_WORDS_PER_PAGE(LOG_WORDS_PER_PAGE)
    ) u_share_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(share_start),
        .numerator(numerator),
        .busy(div_busy),
        .done(div_done),
        .quotient(div_quot)
    );

    // Table sizing from the top set bit of the count, with padding.
    always_comb
    begin
        live = req_reg.live_count[L_W-1:0];
        if (live == '0)
        begin
            live = L_W'(1);
        end
        top = '0;
        for (int i = 0; i < L_W; i++)
        begin
            if (live[i])
            begin
                top = TOP_W'(i);
            end
        end
        base = ((live & (live - 1'b1)) == '0) ? T_W'(live) : (T_W'(1) << (int'(top) + 1));
        pad_prod = (L_W+PCT_W)'(live) * (L_W+PCT_W)'(pad_reg);
        pad_bound = PADP_W'(base - T_W'(live) + T_W'(1)) * PADP_W'(tesa_pkg::PCT_FULL);
        size_next = (PADP_W'(pad_prod) >= pad_bound) ? (T_W'(1) << (int'(top) + 2)) : base;
    end

    // Bound checks against both ends and the share limit; reset commands return an end to its origin.
    always_comb
    begin
        size_ext = WORD_W'(size_reg);
        low_sum = {1'b0, low_end_reg} + {1'b0, size_ext};
        high_diff = high_end_reg - size_ext;
        grant_low = low_end_reg;
        grant_high = high_end_reg;
        rsp_next.status = tesa_pkg::STATUS_OK;
        rsp_next.table_start = '0;
        rsp_next.table_length = '0;
        unique case (req_reg.command)
            tesa_pkg::CMD_ALLOC_LOW:
            begin
                priority if (low_sum > {1'b0, high_end_reg})
                    rsp_next.status = tesa_pkg::STATUS_CROSS;
                else if (low_sum > {1'b0, share_reg})
                    rsp_next.status = tesa_pkg::STATUS_SHARE;
                else
                begin
                    rsp_next.table_start = START_W'(low_end_reg);
                    rsp_next.table_length = LENGTH_W'(size_reg);
                    grant_low = low_sum[WORD_W-1:0];
                end
            end
            tesa_pkg::CMD_ALLOC_HIGH:
            begin
                priority if ((size_ext > high_end_reg) || (high_diff < low_end_reg))
                    rsp_next.status = tesa_pkg::STATUS_CROSS;
                else if (high_diff < floor_reg)
                    rsp_next.status = tesa_pkg::STATUS_SHARE;
                else
                begin
                    rsp_next.table_start = START_W'(high_diff);
                    rsp_next.table_length = LENGTH_W'(size_reg);
                    grant_high = high_diff;
                end
            end
            tesa_pkg::CMD_RESET_LOW:
                grant_low = '0;
            tesa_pkg::CMD_RESET_HIGH:
                grant_high = words;
        endcase
    end

    always_comb
    begin
        low_end_next = low_end_reg;
        high_end_next = high_end_reg;
        priority if (region_write)
        begin
            low_end_next = '0;
            high_end_next = words_next;
        end
        else if (cmd.exec_en)
        begin
            low_end_next = grant_low;
            high_end_next = grant_high;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pages_reg <= tesa_pkg::PAGES_MAX;
            pct_reg <= tesa_pkg::PCT_FULL;
            pad_reg <= '0;
            low_end_reg <= '0;
            high_end_reg <= WORD_W'(tesa_pkg::PAGES_MAX) << LOG_WORDS_PER_PAGE;
            share_reg <= WORD_W'(tesa_pkg::PAGES_MAX) << LOG_WORDS_PER_PAGE;
            floor_reg <= '0;
        end
        else
        begin
            pages_reg <= pages_next;
            pct_reg <= pct_next;
            pad_reg <= pad_next;
            low_end_reg <= low_end_next;
            high_end_reg <= high_end_next;
            share_reg <= share_next;
            floor_reg <= floor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req_data;
        end
        if (cmd.size_en)
        begin
            size_reg <= size_next;
        end
        if (cmd.exec_en)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign status.share_busy = div_busy;
    assign rsp_data = rsp_reg;

    // The two ends never pass each other.
    assert property (@(posedge clk) disable iff (!rst_n)
        low_end_reg <= high_end_reg)
        else $error("bottom end above top end");

    // Once the share limit is settled, the two limits add up to the region size.
    assert property (@(posedge clk) disable iff (!rst_n)
        !div_busy |-> (({1'b0, floor_reg} + {1'b0, share_reg}) == {1'b0, words}))
        else $error("share limits inconsistent with region size");

endmodule

// ===== src/tesa_ctrl.sv =====
// Controller state machine that sequences each request through sizing and checking.
module tesa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  tesa_pkg::dp_status_t status,
    output tesa_pkg::dp_cmd_t    cmd
);

    tesa_pkg::state_t state_reg, state_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic             rsp_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tesa_pkg::ST_IDLE:
                if (req_valid && req_ready)
                    state_next = tesa_pkg::ST_SIZE;
            tesa_pkg::ST_SIZE:
                state_next = tesa_pkg::ST_EXEC;
            tesa_pkg::ST_EXEC:
                if (rsp_free)
                    state_next = tesa_pkg::ST_IDLE;
            default:
                state_next = tesa_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        rsp_free = !rsp_valid_reg || rsp_ready;
        req_ready = (state_reg == tesa_pkg::ST_IDLE) && !status.share_busy;
        cmd.load_req = req_valid && req_ready;
        cmd.size_en = (state_reg == tesa_pkg::ST_SIZE);
        cmd.exec_en = (state_reg == tesa_pkg::ST_EXEC) && rsp_free;
        priority if (cmd.exec_en)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tesa_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    // Sizing always advances to checking in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tesa_pkg::ST_SIZE) |=> (state_reg == tesa_pkg::ST_EXEC))
        else $error("sizing did not advance to checking");

    // A checked request always shows up as a pending response.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec_en |=> rsp_valid_reg)
        else $error("response lost after checking");

endmodule

// ===== test/tesa_grant_checker.sv =====
// Checker that predicts every allocator response from the observed requests and compares it.
module tesa_grant_checker #(
    parameter int LOG_WORDS_PER_PAGE = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tesa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tesa_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           req_valid,
    input  logic                           req_ready,
    input  tesa_pkg::req_t                 req_data,
    input  logic                           rsp_valid,
    input  logic                           rsp_ready,
    input  tesa_pkg::rsp_t                 rsp_data,
    output int unsigned                    pending,
    output int unsigned                    failures
);

    logic [tesa_pkg::PAGES_W-1:0] pages_reg;
    logic [tesa_pkg::PCT_W-1:0]   share_reg;
    logic [tesa_pkg::PCT_W-1:0]   pad_reg;
    logic [24:0]                  low_end_q;
    logic [24:0]                  high_end_q;
    tesa_pkg::rsp_t               expected_grants[$];
    int unsigned                  fail_count;

    function automatic logic [31:0] region_words();
        logic [31:0] p;
        p = 32'(pages_reg);
        if (p == 0) p = 1;
        if (p > 32'(tesa_pkg::PAGES_MAX)) p = 32'(tesa_pkg::PAGES_MAX);
        return p << LOG_WORDS_PER_PAGE;
    endfunction

    function automatic logic [31:0] share_words();
        logic [31:0] pct;
        pct = 32'(share_reg);
        if (pct < 32'(tesa_pkg::PCT_MIN_SHARE)) pct = 32'(tesa_pkg::PCT_MIN_SHARE);
        if (pct > 32'(tesa_pkg::PCT_FULL)) pct = 32'(tesa_pkg::PCT_FULL);
        return (region_words() * pct) / 32'(tesa_pkg::PCT_FULL);
    endfunction

    function automatic logic [31:0] table_words(logic [tesa_pkg::COUNT_W-1:0] count);
        logic [31:0] l;
        logic [31:0] base;
        logic [31:0] padded;
        int          top;
        l = 32'(count);
        if (l == 0) l = 1;
        top = 0;
        for (int i = 0; i < tesa_pkg::COUNT_W; i++)
        begin
            if (l[i]) top = i;
        end
        base = ((l & (l - 1)) == 0) ? l : (32'd1 << (top + 1));
        padded = l + (l * 32'(pad_reg)) / 32'(tesa_pkg::PCT_FULL);
        if (padded > base) return 32'd1 << (top + 2);
        return base;
    endfunction

    function automatic tesa_pkg::rsp_t predict_grant(tesa_pkg::req_t rq);
        tesa_pkg::rsp_t res;
        logic [31:0]    w;
        logic [31:0]    s;
        logic [31:0]    t;
        logic [31:0]    ne;
        res.status = tesa_pkg::STATUS_OK;
        res.table_start = '0;
        res.table_length = '0;
        w = region_words();
        s = share_words();
        case (rq.command)
            tesa_pkg::CMD_ALLOC_LOW:
            begin
                t = table_words(rq.live_count);
                ne = 32'(low_end_q) + t;
                if (ne > 32'(high_end_q)) res.status = tesa_pkg::STATUS_CROSS;
                else if (ne > s) res.status = tesa_pkg::STATUS_SHARE;
                else
                begin
                    res.table_start = low_end_q[tesa_pkg::START_W-1:0];
                    res.table_length = t[tesa_pkg::LENGTH_W-1:0];
                    low_end_q = ne[24:0];
                end
            end
            tesa_pkg::CMD_ALLOC_HIGH:
            begin
                t = table_words(rq.live_count);
                if (t > 32'(high_end_q) || 32'(high_end_q) - t < 32'(low_end_q))
                    res.status = tesa_pkg::STATUS_CROSS;
                else if (32'(high_end_q) - t < w - s)
                    res.status = tesa_pkg::STATUS_SHARE;
                else
                begin
                    high_end_q = high_end_q - t[24:0];
                    res.table_start = high_end_q[tesa_pkg::START_W-1:0];
                    res.table_length = t[tesa_pkg::LENGTH_W-1:0];
                end
            end
            tesa_pkg::CMD_RESET_LOW: low_end_q = '0;
            default: high_end_q = region_words();
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        tesa_pkg::rsp_t want;
        if (!rst_n)
        begin
            pages_reg = tesa_pkg::PAGES_MAX;
            share_reg = tesa_pkg::PCT_FULL;
            pad_reg = '0;
            low_end_q = '0;
            high_end_q = region_words();
            expected_grants.delete();
            fail_count = 0;
            pending <= 0;
            failures <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tesa_pkg::CFG_REGION_PAGES:
                    begin
                        pages_reg = cfg_data[tesa_pkg::PAGES_W-1:0];
                        low_end_q = '0;
                        high_end_q = region_words();
                    end
                    tesa_pkg::CFG_MAX_SHARE: share_reg = cfg_data[tesa_pkg::PCT_W-1:0];
                    tesa_pkg::CFG_PAD: pad_reg = cfg_data[tesa_pkg::PCT_W-1:0];
                    default: ;
                endcase
            end
            if (rsp_valid && rsp_ready)
            begin
                if (expected_grants.size() == 0)
                begin
                    $error("response with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (rsp_data.status !== want.status)
                    begin
                        $error("status expected %0d got %0d", want.status, rsp_data.status);
                        fail_count++;
                    end
                    if (rsp_data.table_start !== want.table_start)
                    begin
                        $error("table_start expected %0d got %0d",
                               want.table_start, rsp_data.table_start);
                        fail_count++;
                    end
                    if (rsp_data.table_length !== want.table_length)
                    begin
                        $error("table_length expected %0d got %0d",
                               want.table_length, rsp_data.table_length);
                        fail_count++;
                    end
                end
            end
            if (req_valid && req_ready) expected_grants.push_back(predict_grant(req_data));
            pending <= expected_grants.size();
            failures <= fail_count;
        end
    end

endmodule

// ===== test/tb_two_ended_table_space_allocator.sv =====
// Top of the allocator testbench: clock, reset, request and configuration stimulus, verdict.
module tb_two_ended_table_space_allocator;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam logic [tesa_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [tesa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tesa_pkg::CFG_W-1:0]     cfg_data = '0;
    logic                           req_valid = 1'b0;
    logic                           req_ready;
    tesa_pkg::req_t                 req_data = '0;
    logic                           rsp_valid;
    logic                           rsp_ready = 1'b0;
    tesa_pkg::rsp_t                 rsp_data;
    int unsigned                    pending;
    int unsigned                    failures;
    int unsigned                    idle_cycles = 0;
    logic                           calm_send = 1'b0;
    logic                           calm_recv = 1'b0;

    two_ended_table_space_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    tesa_grant_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .pending   (pending),
        .failures  (failures)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("two_ended_table_space_allocator test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_request(tesa_pkg::cmd_t cmd, logic [tesa_pkg::COUNT_W-1:0] count);
        int gap;
        gap = calm_send ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data.command <= cmd;
        req_data.live_count <= count;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_register(logic [tesa_pkg::CFG_IDX_W-1:0] idx,
                                  logic [tesa_pkg::CFG_W-1:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : receiver
        int stall;
        while (!rst_n) @(posedge clk);
        forever
        begin
            stall = calm_recv ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    initial
    begin : stimulus
        tesa_pkg::cmd_t               cmd;
        logic [tesa_pkg::COUNT_W-1:0] count;
        int                           k;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default setting: full region, full share, no padding.
        send_request(tesa_pkg::CMD_ALLOC_LOW, 16'd1);
        send_request(tesa_pkg::CMD_ALLOC_LOW, 16'd0);
        send_request(tesa_pkg::CMD_ALLOC_LOW, 16'hFFFF);
        send_request(tesa_pkg::CMD_ALLOC_LOW, 16'd32768);
        send_request(tesa_pkg::CMD_ALLOC_LOW, 16'd5);
        send_request(tesa_pkg::CMD_ALLOC_HIGH, 16'd1);
        send_request(tesa_pkg::CMD_ALLOC_HIGH, 16'hFFFF);
        send_request(tesa_pkg::CMD_ALLOC_HIGH, 16'd4096);
        send_request(tesa_pkg::CMD_ALLOC_HIGH, 16'd3);
        send_request(tesa_pkg::CMD_RESET_LOW, 16'hFFFF);
        send_request(tesa_pkg::CMD_RESET_HIGH, 16'd0);

        // Padding pushes tables two steps above the top bit.
        write_register(tesa_pkg::CFG_PAD, 13'd100);
        send_request(tesa_pkg::CMD_ALLOC_LOW, 16'd4);
        send_request(tesa_pkg::CMD_ALLOC_LOW, 16'd3);
        send_request(tesa_pkg::CMD_ALLOC_HIGH, 16'hFFFF);

        // One page, half share: crossing wins over share, oversized top tables cross.
        write_register(tesa_pkg::CFG_REGION_PAGES, 13'd1);
        write_register(tesa_pkg::CFG_MAX_SHARE, 13'd50);
        send_request(tesa_pkg::CMD_ALLOC_LOW, 16'd2048);
        send_request(tesa_pkg::CMD_ALLOC_LOW, 16'd600);
        send_request(tesa_pkg::CMD_ALLOC_HIGH, 16'hFFFF);
        send_request(tesa_pkg::CMD_ALLOC_HIGH, 16'd500);
        send_request(tesa_pkg::CMD_ALLOC_LOW, 16'd1);

        // Out-of-range settings are clamped; the unused index is ignored.
        write_register(tesa_pkg::CFG_MAX_SHARE, 13'd0);
        send_request(tesa_pkg::CMD_ALLOC_LOW, 16'd256);
        write_register(tesa_pkg::CFG_MAX_SHARE, 13'h1FFF);
        write_register(tesa_pkg::CFG_PAD, 13'd127);
        send_request(tesa_pkg::CMD_ALLOC_HIGH, 16'd100);
        write_register(CFG_UNUSED, 13'h1FFF);
        write_register(tesa_pkg::CFG_REGION_PAGES, 13'd0);
        send_request(tesa_pkg::CMD_ALLOC_LOW, 16'd1000);
        write_register(tesa_pkg::CFG_REGION_PAGES, 13'h1FFF);
        send_request(tesa_pkg::CMD_ALLOC_HIGH, 16'hFFFF);

        for (int phase = 0; phase < 10; phase++)
        begin
            if (phase == 0)
            begin
                write_register(tesa_pkg::CFG_REGION_PAGES, 13'd1);
                write_register(tesa_pkg::CFG_MAX_SHARE, 13'd50);
                write_register(tesa_pkg::CFG_PAD, 13'd100);
            end
            else if (phase == 1)
            begin
                write_register(tesa_pkg::CFG_REGION_PAGES, 13'd4096);
                write_register(tesa_pkg::CFG_MAX_SHARE, 13'd100);
                write_register(tesa_pkg::CFG_PAD, 13'd0);
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0: write_register(tesa_pkg::CFG_REGION_PAGES, 13'd1);
                    1: write_register(tesa_pkg::CFG_REGION_PAGES, 13'd4096);
                    2: write_register(tesa_pkg::CFG_REGION_PAGES,
                                      13'($urandom_range(1, 16)));
                    3: write_register(tesa_pkg::CFG_REGION_PAGES,
                                      13'($urandom_range(1, 4096)));
                    default: write_register(tesa_pkg::CFG_REGION_PAGES,
                                            13'($urandom_range(0, 8191)));
                endcase
                case ($urandom_range(0, 3))
                    0: write_register(tesa_pkg::CFG_MAX_SHARE, 13'd50);
                    1: write_register(tesa_pkg::CFG_MAX_SHARE, 13'd100);
                    2: write_register(tesa_pkg::CFG_MAX_SHARE,
                                      13'($urandom_range(50, 100)));
                    default: write_register(tesa_pkg::CFG_MAX_SHARE,
                                            13'($urandom_range(0, 8191)));
                endcase
                case ($urandom_range(0, 3))
                    0: write_register(tesa_pkg::CFG_PAD, 13'd0);
                    1: write_register(tesa_pkg::CFG_PAD, 13'd100);
                    2: write_register(tesa_pkg::CFG_PAD, 13'($urandom_range(0, 100)));
                    default: write_register(tesa_pkg::CFG_PAD, 13'($urandom_range(0, 8191)));
                endcase
                if ($urandom_range(0, 3) == 0)
                    write_register(CFG_UNUSED, 13'($urandom_range(0, 8191)));
            end
            for (int n = 0; n < 200; n++)
            begin
                if (n % 50 == 0)
                begin
                    calm_send = ($urandom_range(0, 3) == 0);
                    calm_recv = ($urandom_range(0, 3) == 0);
                end
                // The share limit follows a share change, and sizing a padding change, while both ends stay put.
                if (n == 100)
                begin
                    if ($urandom_range(0, 1) == 0)
                        write_register(tesa_pkg::CFG_MAX_SHARE,
                                       13'($urandom_range(50, 100)));
                    else
                        write_register(tesa_pkg::CFG_PAD, 13'($urandom_range(0, 100)));
                end
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8: cmd = tesa_pkg::CMD_ALLOC_LOW;
                    18: cmd = tesa_pkg::CMD_RESET_LOW;
                    19: cmd = tesa_pkg::CMD_RESET_HIGH;
                    default: cmd = tesa_pkg::CMD_ALLOC_HIGH;
                endcase
                k = $urandom_range(0, 15);
                case ($urandom_range(0, 4))
                    0: count = 16'($urandom_range(0, 65535));
                    1: count = 16'($urandom_range(0, 64));
                    2: count = 16'(32'd1 << k);
                    3: count = ($urandom_range(0, 1) == 0) ? 16'((32'd1 << k) + 1)
                                                           : 16'((32'd1 << k) - 1);
                    default: count = 16'($urandom_range(0, 4096));
                endcase
                send_request(cmd, count);
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("two_ended_table_space_allocator test passed");
        else
            $display("two_ended_table_space_allocator test failed");
        $finish;
    end

endmodule
